// ----- sv/wesm_pkg.sv -----
package wesm_pkg;

   // Register byte addresses on the CSR port
   localparam logic [3:0] ADDR_ENABLE = 4'h0;
   localparam logic [3:0] ADDR_RADIUS = 4'h4;
   localparam logic [3:0] ADDR_CPR    = 4'h8;

   // Fixed-point scale factors
   localparam logic [18:0] TWO_PI_Q16 = 19'd411775;  // round(2*pi*65536)
   localparam logic [13:0] RATE_MUL   = 14'd15625;
   localparam logic [6:0]  SPEED_MUL  = 7'd125;

   // Datapath widths
   localparam int CK_W    = 51;  // 32-bit count * 19-bit constant
   localparam int CRK_W   = 63;  // ck * 12-bit radius
   localparam int NR_W    = 65;  // ck * 15625
   localparam int NUM_W   = 70;  // crk * 125, widest dividend
   localparam int DEN_W   = 45;  // n * t * 8192, widest divisor
   localparam int CNT_W   = 7;   // divider step counter
   localparam int RSP_W   = 312;
   localparam int REQ_W   = 8;

   // Window snapshot handed from the counter side to the compute side
   typedef struct packed {
      logic [15:0] elapsed;
      logic [31:0] right_total;
      logic [31:0] left_total;
      logic [31:0] right_cnt;
      logic [31:0] left_cnt;
   } snap_type;

   // Result transaction, last field in the low bits
   typedef struct packed {
      logic [6:0]  pad;
      logic        zero_time;
      logic [31:0] right_speed;
      logic [31:0] left_speed;
      logic [31:0] right_rate;
      logic [31:0] left_rate;
      logic [31:0] right_distance;
      logic [31:0] left_distance;
      logic [15:0] elapsed_ms;
      logic [31:0] right_total;
      logic [31:0] left_total;
      logic [15:0] right_count;
      logic [15:0] left_count;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CK,
      ST_CRK,
      ST_NR,
      ST_NS,
      ST_NT,
      ST_DGO,
      ST_DWAIT,
      ST_WHEEL,
      ST_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      SEL_DIST,
      SEL_RATE,
      SEL_SPEED
   } div_sel_type;

endpackage

// ----- sv/wheel_encoder_speed_meter_top.sv -----
// Wheel encoder speed meter. Each req transaction carries one cycle's worth of
// encoder pulses, a millisecond tick and sample/clear requests; the counters
// take one transaction per clock with no gaps while the snapshot queue (two
// entries) has room. An enabled sample pushes a window snapshot; the compute
// side then works it off (per wheel five registered
// multiplies plus up to three 70-step restoring divisions on one shared
// divider) and presents one rsp transaction. req_tready drops only when two
// snapshots are already waiting, so sustained sampling is bounded by that
// divider; ordinary pulse traffic runs at one transaction per cycle.
module wheel_encoder_speed_meter_top
   import wesm_pkg::*;
#(
   parameter int WINDOW_COUNT_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   // fields from bit 0: left_pulse, right_pulse, ms_tick, sample,
   // clear_left, clear_right, zero fill
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   // fields from bit 0: left_count, right_count, left_total, right_total,
   // elapsed_ms, left_distance, right_distance, left_rate, right_rate,
   // left_speed, right_speed, zero_time, zero fill
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic          enable_ff;
   logic [11:0]   radius_ff;
   logic [15:0]   cpr_ff;
   logic          csr_wr;
   logic          accept;
   logic          push;
   logic          pop;
   snap_type      push_snap, pop_snap;
   fifo_stat_type fifo_stat;
   result_type    rsp_data;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         radius_ff <= 12'd20;
         cpr_ff    <= 16'd1024;
      end else if (csr_wr) begin
         case (csr_paddr)
            ADDR_ENABLE: enable_ff <= csr_pwdata[0];
            ADDR_RADIUS: radius_ff <= csr_pwdata[11:0];
            ADDR_CPR:    cpr_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_ENABLE: csr_prdata = 32'(enable_ff);
         ADDR_RADIUS: csr_prdata = 32'(radius_ff);
         ADDR_CPR:    csr_prdata = 32'(cpr_ff);
         default:     csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = !fifo_stat.full;
   assign accept     = req_tvalid && req_tready;

   wesm_front #(
      .WINDOW_COUNT_WIDTH (WINDOW_COUNT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .left_pulse  (req_tdata[0]),
      .right_pulse (req_tdata[1]),
      .ms_tick     (req_tdata[2]),
      .sample      (req_tdata[3]),
      .clear_left  (req_tdata[4]),
      .clear_right (req_tdata[5]),
      .enable      (enable_ff),
      .push        (push),
      .snap        (push_snap)
   );

   wesm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_snap),
      .pop       (pop),
      .pop_data  (pop_snap),
      .stat      (fifo_stat)
   );

   wesm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .snap      (pop_snap),
      .fifo_stat (fifo_stat),
      .pop       (pop),
      .radius    (radius_ff),
      .cpr       (cpr_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = rsp_data;

endmodule

// ----- sv/wesm_front.sv -----
module wesm_front
   import wesm_pkg::*;
#(
   parameter int WINDOW_COUNT_WIDTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic          left_pulse,
   input  logic          right_pulse,
   input  logic          ms_tick,
   input  logic          sample,
   input  logic          clear_left,
   input  logic          clear_right,
   input  logic          enable,
   output logic          push,
   output snap_type      snap
);

   localparam logic [WINDOW_COUNT_WIDTH-1:0] WIN_MAX = '1;

   logic [WINDOW_COUNT_WIDTH-1:0] lwin_ff, lwin_in, rwin_ff, rwin_in;
   logic [31:0]                   ltot_ff, ltot_in, rtot_ff, rtot_in;
   logic [15:0]                   ms_ff, ms_in;
   logic                          take;

   // Count pulses and ticks, snapshot on an enabled sample, then apply clears
   always_comb begin
      lwin_in = lwin_ff;
      rwin_in = rwin_ff;
      ltot_in = ltot_ff;
      rtot_in = rtot_ff;
      ms_in   = ms_ff;
      if (left_pulse) begin
         if (lwin_ff != WIN_MAX) lwin_in = lwin_ff + 1'b1;
         ltot_in = ltot_ff + 32'd1;
      end
      if (right_pulse) begin
         if (rwin_ff != WIN_MAX) rwin_in = rwin_ff + 1'b1;
         rtot_in = rtot_ff + 32'd1;
      end
      if (ms_tick && ms_ff != 16'hFFFF) ms_in = ms_ff + 16'd1;

      take              = sample && enable;
      snap.left_cnt     = 32'(lwin_in);
      snap.right_cnt    = 32'(rwin_in);
      snap.left_total   = ltot_in;
      snap.right_total  = rtot_in;
      snap.elapsed      = ms_in;
      if (take) begin
         lwin_in = '0;
         rwin_in = '0;
         ms_in   = '0;
      end
      if (clear_left) begin
         lwin_in = '0;
         ltot_in = '0;
      end
      if (clear_right) begin
         rwin_in = '0;
         rtot_in = '0;
      end
   end

   assign push = accept && take;

   always_ff @(posedge clock) begin
      if (reset) begin
         lwin_ff <= '0;
         rwin_ff <= '0;
         ltot_ff <= '0;
         rtot_ff <= '0;
         ms_ff   <= '0;
      end else if (accept) begin
         lwin_ff <= lwin_in;
         rwin_ff <= rwin_in;
         ltot_ff <= ltot_in;
         rtot_ff <= rtot_in;
         ms_ff   <= ms_in;
      end
   end

endmodule

// ----- sv/wesm_fifo.sv -----
module wesm_fifo
   import wesm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  snap_type      push_data,
   input  logic          pop,
   output snap_type      pop_data,
   output fifo_stat_type stat
);

   snap_type    mem_ff [2];
   logic        wptr_ff, rptr_ff;
   logic [1:0]  cnt_ff;

   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.empty = (cnt_ff == 2'd0);
   assign pop_data   = mem_ff[rptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

// ----- sv/wesm_div.sv -----
module wesm_div
   import wesm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output div_stat_type     stat,
   output logic [31:0]      quo
);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [31:0]      q_ff;
   logic             ovf_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff, done_ff;
   logic [DEN_W:0]   rem_sh;
   logic             ge;

   // One restoring step per cycle, quotient kept to 32 bits plus overflow
   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         q_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (run_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= rem_in;
         q_ff   <= {q_ff[30:0], ge};
         ovf_ff <= ovf_ff | q_ff[31];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(NUM_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign quo       = ovf_ff ? 32'hFFFF_FFFF : q_ff;

endmodule

// ----- sv/wesm_back.sv -----
module wesm_back
   import wesm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  snap_type      snap,
   input  fifo_stat_type fifo_stat,
   output logic          pop,
   input  logic [11:0]   radius,
   input  logic [15:0]   cpr,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output result_type    rsp_data
);

   back_state_type   state_ff, state_in;
   div_sel_type      sel_ff, sel_in;
   logic             wheel_ff, wheel_in;
   snap_type         snap_ff;
   logic [CK_W-1:0]  ck_ff;
   logic [CRK_W-1:0] crk_ff;
   logic [NR_W-1:0]  nr_ff;
   logic [NUM_W-1:0] ns_ff;
   logic [31:0]      nt_ff;
   logic [31:0]      dist_ff [2];
   logic [31:0]      rate_ff [2];
   logic [31:0]      speed_ff [2];
   logic             rsp_valid_ff;
   result_type       rsp_data_ff;
   logic [31:0]      cnt;
   logic             t_zero;
   logic             div_start;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic [31:0]      div_quo;
   div_stat_type     div_stat;
   logic             load_out;

   assign cnt    = wheel_ff ? snap_ff.right_cnt : snap_ff.left_cnt;
   assign t_zero = (snap_ff.elapsed == 16'd0);

   // Shared divider for distance, rate and speed of both wheels
   wesm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   always_comb begin
      case (sel_ff)
         SEL_RATE: begin
            div_num = NUM_W'(nr_ff);
            div_den = DEN_W'({nt_ff, 10'd0});
         end
         SEL_SPEED: begin
            div_num = ns_ff;
            div_den = DEN_W'({nt_ff, 13'd0});
         end
         default: begin
            div_num = NUM_W'(crk_ff);
            div_den = DEN_W'({cpr, 8'd0});
         end
      endcase
   end

   // Sequencer: next state and strobes
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      wheel_in  = wheel_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!fifo_stat.empty) begin
               pop      = 1'b1;
               wheel_in = 1'b0;
               state_in = ST_CK;
            end
         end
         ST_CK:    state_in = (cpr == 16'd0) ? ST_WHEEL : ST_CRK;
         ST_CRK:   state_in = ST_NR;
         ST_NR:    state_in = ST_NS;
         ST_NS:    state_in = ST_NT;
         ST_NT: begin
            sel_in   = SEL_DIST;
            state_in = ST_DGO;
         end
         ST_DGO: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_stat.done) begin
               case (sel_ff)
                  SEL_DIST: begin
                     sel_in   = SEL_RATE;
                     state_in = t_zero ? ST_WHEEL : ST_DGO;
                  end
                  SEL_RATE: begin
                     sel_in   = SEL_SPEED;
                     state_in = ST_DGO;
                  end
                  default:  state_in = ST_WHEEL;
               endcase
            end
         end
         ST_WHEEL: begin
            if (!wheel_ff) begin
               wheel_in = 1'b1;
               state_in = ST_CK;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_DIST;
         wheel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         wheel_ff <= wheel_in;
      end
   end

   // Products, one registered multiply per step
   always_ff @(posedge clock) begin
      if (pop) snap_ff <= snap;
      case (state_ff)
         ST_CK: begin
            ck_ff              <= CK_W'(cnt) * CK_W'(TWO_PI_Q16);
            dist_ff[wheel_ff]  <= '0;
            rate_ff[wheel_ff]  <= '0;
            speed_ff[wheel_ff] <= '0;
         end
         ST_CRK: crk_ff <= CRK_W'(ck_ff) * CRK_W'(radius);
         ST_NR:  nr_ff  <= NR_W'(ck_ff) * NR_W'(RATE_MUL);
         ST_NS:  ns_ff  <= NUM_W'(crk_ff) * NUM_W'(SPEED_MUL);
         ST_NT:  nt_ff  <= 32'(cpr) * 32'(snap_ff.elapsed);
         ST_DWAIT: begin
            if (div_stat.done) begin
               case (sel_ff)
                  SEL_DIST: dist_ff[wheel_ff]  <= div_quo;
                  SEL_RATE: rate_ff[wheel_ff]  <= div_quo;
                  default:  speed_ff[wheel_ff] <= div_quo;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff.pad            <= '0;
         rsp_data_ff.zero_time      <= t_zero;
         rsp_data_ff.left_count     <= (snap_ff.left_cnt > 32'hFFFF) ? 16'hFFFF
                                       : 16'(snap_ff.left_cnt);
         rsp_data_ff.right_count    <= (snap_ff.right_cnt > 32'hFFFF) ? 16'hFFFF
                                       : 16'(snap_ff.right_cnt);
         rsp_data_ff.left_total     <= snap_ff.left_total;
         rsp_data_ff.right_total    <= snap_ff.right_total;
         rsp_data_ff.elapsed_ms     <= snap_ff.elapsed;
         rsp_data_ff.left_distance  <= dist_ff[0];
         rsp_data_ff.right_distance <= dist_ff[1];
         rsp_data_ff.left_rate      <= rate_ff[0];
         rsp_data_ff.right_rate     <= rate_ff[1];
         rsp_data_ff.left_speed     <= speed_ff[0];
         rsp_data_ff.right_speed    <= speed_ff[1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Divider is never restarted mid-run
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // A snapshot is only taken from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_stat.empty)
      else $error("pop from empty queue");

   // Zero elapsed time forces zero rate and speed
   a_zero_time_rates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.zero_time) |->
         (rsp_data_ff.left_rate == 32'd0 && rsp_data_ff.right_rate == 32'd0 &&
          rsp_data_ff.left_speed == 32'd0 && rsp_data_ff.right_speed == 32'd0))
      else $error("nonzero rate with zero elapsed time");

   // Divider done only arrives while waiting for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DWAIT)
      else $error("divider result with no one waiting");

endmodule

// ----- bench/wesm_checker.sv -----
// Watches the req, rsp and csr channels, tracks the meter state and
// compares every measurement transaction with the predicted one.
module wesm_checker
   import wesm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   input  logic             csr_pready,
   output int               fail_count,
   output int               pending,
   output int               meas_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow configuration
   logic        cfg_enable;
   logic [11:0] cfg_radius;
   logic [15:0] cfg_cpr;
   // shadow counters
   logic [15:0] win_l, win_r, ms_cnt;
   logic [31:0] tot_l, tot_r;

   result_type expected_meas[$];
   int         mismatches;

   assign pending    = expected_meas.size();
   assign fail_count = mismatches;

   // floor(num*mul/den), saturated to 32 bits
   function automatic logic [31:0] sat_muldiv(logic [127:0] num, logic [127:0] mul,
                                              logic [127:0] den);
      logic [127:0] q, r, res;
      q = num / den;
      r = num % den;
      if (q > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
      res = q * mul + (r * mul) / den;
      if (res > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return res[31:0];
   endfunction

   // distance, angular rate and speed of one wheel
   task automatic wheel_math(input logic [15:0] cnt, input logic [15:0] t,
                             output logic [31:0] dist_v, output logic [31:0] rate,
                             output logic [31:0] speed);
      logic [127:0] ck, crk, n;
      n    = cfg_cpr;
      ck   = 128'(cnt) * 128'(TWO_PI_Q16);
      crk  = ck * 128'(cfg_radius);
      dist_v = 0;
      rate = 0;
      speed = 0;
      if (n != 0) begin
         dist_v = sat_muldiv(crk, 1, 256 * n);
         if (t != 0) begin
            rate  = sat_muldiv(ck, 15625, 1024 * n * 128'(t));
            speed = sat_muldiv(crk, 125, 8192 * n * 128'(t));
         end
      end
   endtask

   // advance the counters by one req transaction
   task automatic step_meter(input logic [REQ_W-1:0] d);
      result_type m;
      if (d[0]) begin
         if (win_l != 16'hFFFF) win_l++;
         tot_l++;
      end
      if (d[1]) begin
         if (win_r != 16'hFFFF) win_r++;
         tot_r++;
      end
      if (d[2] && ms_cnt != 16'hFFFF) ms_cnt++;
      if (d[3] && cfg_enable) begin
         m = '0;
         m.left_count  = win_l;
         m.right_count = win_r;
         m.left_total  = tot_l;
         m.right_total = tot_r;
         m.elapsed_ms  = ms_cnt;
         m.zero_time   = (ms_cnt == 0);
         wheel_math(win_l, ms_cnt, m.left_distance, m.left_rate, m.left_speed);
         wheel_math(win_r, ms_cnt, m.right_distance, m.right_rate, m.right_speed);
         expected_meas.push_back(m);
         win_l  = 0;
         win_r  = 0;
         ms_cnt = 0;
      end
      if (d[4]) begin
         win_l = 0;
         tot_l = 0;
      end
      if (d[5]) begin
         win_r = 0;
         tot_r = 0;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t mismatch %s: expected %0d, got %0d", $realtime, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      result_type e, a;
      if (reset) begin
         cfg_enable = 0;
         cfg_radius = 20;
         cfg_cpr    = 1024;
         win_l = 0; win_r = 0; ms_cnt = 0; tot_l = 0; tot_r = 0;
         expected_meas.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               ADDR_ENABLE: cfg_enable = csr_pwdata[0];
               ADDR_RADIUS: cfg_radius = csr_pwdata[11:0];
               ADDR_CPR:    cfg_cpr    = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) step_meter(req_tdata);
         // compare a delivered measurement
         if (rsp_tvalid && rsp_tready) begin
            meas_seen++;
            a = result_type'(rsp_tdata);
            if (expected_meas.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("%0t unexpected measurement transaction", $realtime);
            end else begin
               e = expected_meas.pop_front();
               check_field("left_count", e.left_count, a.left_count);
               check_field("right_count", e.right_count, a.right_count);
               check_field("left_total", e.left_total, a.left_total);
               check_field("right_total", e.right_total, a.right_total);
               check_field("elapsed_ms", e.elapsed_ms, a.elapsed_ms);
               check_field("left_distance", e.left_distance, a.left_distance);
               check_field("right_distance", e.right_distance, a.right_distance);
               check_field("left_rate", e.left_rate, a.left_rate);
               check_field("right_rate", e.right_rate, a.right_rate);
               check_field("left_speed", e.left_speed, a.left_speed);
               check_field("right_speed", e.right_speed, a.right_speed);
               check_field("zero_time", e.zero_time, a.zero_time);
               check_field("pad", e.pad, a.pad);
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      meas_seen  = 0;
   end
endmodule

// ----- bench/tb_wheel_encoder_speed_meter_top.sv -----
module tb_wheel_encoder_speed_meter_top;
   import wesm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE = 1000;  // extra wait in drain after the last measurement is out

   logic             clock = 0;
   logic             reset = 1;
   logic             req_tvalid = 0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]       csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;
   int               fail_count, pending, meas_seen;
   int               cycles = 0;
   int               items_sent = 0;
   bit               burst_mode = 0;

   wheel_encoder_speed_meter_top dut (.*);

   wesm_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .rsp_tvalid, .rsp_tready,
      .rsp_tdata, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_pready, .fail_count, .pending, .meas_seen
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_wheel_encoder_speed_meter_top: FAIL");
         $finish;
      end
   end

   function automatic int draw_gap();
      if (burst_mode) return 0;
      return $urandom_range(0, 17);
   endfunction

   // result side back-pressure
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
   endtask

   task automatic send_item(input logic [5:0] fields);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {2'b00, fields};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // hold off until every measurement is out and the divider has drained
   task automatic drain();
      if (req_tvalid) req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input logic en, input logic [11:0] radius,
                            input logic [15:0] cpr);
      csr_write(ADDR_ENABLE, {31'b0, en});
      csr_write(ADDR_RADIUS, {20'b0, radius});
      csr_write(ADDR_CPR, {16'b0, cpr});
   endtask

   // one random transaction; sample_odds is 1-in-N for a sample request
   task automatic random_item(input int sample_odds, input int tick_odds);
      logic [5:0] f;
      f[0] = $urandom_range(0, 3) != 0;
      f[1] = $urandom_range(0, 2) != 0;
      f[2] = $urandom_range(1, tick_odds) == 1;
      f[3] = $urandom_range(1, sample_odds) == 1;
      f[4] = $urandom_range(0, 29) == 0;
      f[5] = $urandom_range(0, 29) == 0;
      send_item(f);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: sample while disabled at reset values, then enabled
      send_item(6'b000111);
      send_item(6'b001011);   // disabled sample, counts keep running
      drain();
      configure(1, 20, 1024);
      send_item(6'b001000);   // first enabled sample, window carried over from the disabled phase
      send_item(6'b001000);   // empty window, zero time
      send_item(6'b000111);
      send_item(6'b000111);
      send_item(6'b001111);   // pulses and tick land before the snapshot
      send_item(6'b111111);   // everything at once, clears after sample
      send_item(6'b000011);
      send_item(6'b001000);   // zero time, nonzero counts
      send_item(6'b010101);
      send_item(6'b100110);
      send_item(6'b001100);
      send_item(6'b011001);
      send_item(6'b101010);
      send_item(6'b001000);
      drain();
      configure(1, 12'd4095, 16'd1);   // largest radius, one pulse per rev
      for (int i = 0; i < 6; i++) send_item(6'b000011);
      send_item(6'b001100);
      send_item(6'b001111);
      send_item(6'b001000);
      drain();

      // random phases across several settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: configure(1, 12'd1, 16'd65535);
            1: configure(1, 12'd4095, 16'd1);
            2: configure(0, 12'($urandom_range(1, 4095)), 16'($urandom_range(1, 65535)));
            default: configure(1, 12'($urandom_range(1, 4095)),
                               16'($urandom_range(1, 65535)));
         endcase
         burst_mode = (ph == 4);
         for (int i = 0; i < 120; i++)
            random_item((ph == 5) ? 3 : 10, (ph == 3) ? 8 : 2);
         burst_mode = 0;
         drain();
      end

      $display("%0d req transactions, %0d measurements checked over 8 register settings",
               items_sent, meas_seen);
      $display("covered disabled samples, zero elapsed time, clears and radius/cpr extremes");
      if (fail_count == 0) begin
         $display("tb_wheel_encoder_speed_meter_top: PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("tb_wheel_encoder_speed_meter_top: FAIL");
      end
      $finish;
   end
endmodule
